/* src/aftp_pkg.sv */
// Constants and types shared by the three-point affine solver.
package aftp_pkg;

	localparam int CW    = 16;           // coordinate width
	localparam int FB    = 16;           // fraction bits of the results
	localparam int OW    = 32;           // result width
	localparam int AW    = CW + 1;       // first two adjugate rows
	localparam int A2W   = 2 * CW + 1;   // third adjugate row
	localparam int PW    = 2 * CW;       // corner products
	localparam int P01W  = AW + CW;      // products with the first two rows
	localparam int P2W   = A2W + CW;     // products with the third row
	localparam int NW    = P2W + 2;      // numerator, sum of three products
	localparam int DW    = 2 * CW + 4;   // determinant and its magnitude
	localparam int QB    = OW + 2;       // quotient bits resolved by the divider
	localparam int LANES = 6;            // coefficients per request

	typedef struct packed {
		logic          neg;
		logic          presat;
		logic [DW-1:0] rem;
		logic [QB-1:0] nq;
	} div_lane_t;

	typedef struct packed {
		logic [DW-1:0] ud;
		logic          sing;
	} div_item_t;

endpackage

/* src/affine_from_three_point_pairs_unit.sv */
// Top level of the three-point affine solver: a fully pipelined datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_stall  | src_{a,b,c}_{x,y}, dst_{a,b,c}_{x,y}
//   out     | out_valid / out_stall| coef_xx..coef_yy, shift_x/y, flags
//
// One request enters and one result leaves per clock unless out_stall holds;
// 4 front stages, QB+1 divider stages and the output register lie between.
// The latency is set by the long divider, which resolves one quotient bit
// per stage for all six coefficients side by side.
// Reset clears only the valid bits; the datapath registers hold no reset.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and new requests are taken while a result waits stalled.
module affine_from_three_point_pairs_unit import aftp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [CW-1:0] src_a_x,
	input  logic signed [CW-1:0] src_a_y,
	input  logic signed [CW-1:0] src_b_x,
	input  logic signed [CW-1:0] src_b_y,
	input  logic signed [CW-1:0] src_c_x,
	input  logic signed [CW-1:0] src_c_y,
	input  logic signed [CW-1:0] dst_a_x,
	input  logic signed [CW-1:0] dst_a_y,
	input  logic signed [CW-1:0] dst_b_x,
	input  logic signed [CW-1:0] dst_b_y,
	input  logic signed [CW-1:0] dst_c_x,
	input  logic signed [CW-1:0] dst_c_y,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [OW-1:0] coef_xx,
	output logic signed [OW-1:0] coef_xy,
	output logic signed [OW-1:0] coef_yx,
	output logic signed [OW-1:0] coef_yy,
	output logic signed [OW-1:0] shift_x,
	output logic signed [OW-1:0] shift_y,
	output logic                 singular,
	output logic                 saturated
);

	// Stage 1: adjugate rows 0 and 1 (differences) and the corner products.
	logic                  v_s1;
	logic signed [AW-1:0]  d0_s1 [3];
	logic signed [AW-1:0]  d1_s1 [3];
	logic signed [PW-1:0]  pa_s1 [3];
	logic signed [PW-1:0]  pb_s1 [3];
	logic signed [CW-1:0]  dst_s1 [3][2];
	// Stage 2: adjugate row 2.
	logic                  v_s2;
	logic signed [AW-1:0]  d0_s2 [3];
	logic signed [AW-1:0]  d1_s2 [3];
	logic signed [A2W-1:0] a2_s2 [3];
	logic signed [CW-1:0]  dst_s2 [3][2];
	// Stage 3: determinant and all eighteen products.
	logic                  v_s3;
	logic signed [DW-1:0]  det_s3;
	logic signed [P01W-1:0] p0_s3 [3][2];
	logic signed [P01W-1:0] p1_s3 [3][2];
	logic signed [P2W-1:0]  p2_s3 [3][2];
	// Stage 4: numerators.
	logic                  v_s4;
	logic signed [DW-1:0]  det_s4;
	logic signed [NW-1:0]  num_s4 [LANES];
	// Divider stages; index 0 holds the prepared operands.
	logic                  v_sd [QB+1];
	div_item_t             it_sd [QB+1];
	div_lane_t             ln_sd [QB+1][LANES];
	// Output stage.
	logic                  v_so;
	logic [OW-1:0]         res_so [LANES];
	logic                  sing_so;
	logic                  sat_so;

	logic en_s1, en_s2, en_s3, en_s4, en_so;
	logic en_sd [QB+1];

	assign en_so = !v_so || !out_stall;
	assign en_sd[QB] = !v_sd[QB] || en_so;
	for (genvar k = 0; k < QB; k++) begin : g_en
		assign en_sd[k] = !v_sd[k] || en_sd[k+1];
	end
	assign en_s4 = !v_s4 || en_sd[0];
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_so <= 1'b0;
			for (int k = 0; k <= QB; k++) v_sd[k] <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_sd[0]) v_sd[0] <= v_s4;
			for (int k = 1; k <= QB; k++) begin
				if (en_sd[k]) v_sd[k] <= v_sd[k-1];
			end
			if (en_so) v_so <= v_sd[QB];
		end
	end

	// Front stages.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			d0_s1[0] <= AW'(src_b_y) - AW'(src_c_y);
			d0_s1[1] <= AW'(src_c_y) - AW'(src_a_y);
			d0_s1[2] <= AW'(src_a_y) - AW'(src_b_y);
			d1_s1[0] <= AW'(src_c_x) - AW'(src_b_x);
			d1_s1[1] <= AW'(src_a_x) - AW'(src_c_x);
			d1_s1[2] <= AW'(src_b_x) - AW'(src_a_x);
			pa_s1[0] <= PW'(src_b_x) * PW'(src_c_y);
			pa_s1[1] <= PW'(src_c_x) * PW'(src_a_y);
			pa_s1[2] <= PW'(src_a_x) * PW'(src_b_y);
			pb_s1[0] <= PW'(src_c_x) * PW'(src_b_y);
			pb_s1[1] <= PW'(src_a_x) * PW'(src_c_y);
			pb_s1[2] <= PW'(src_b_x) * PW'(src_a_y);
			dst_s1[0][0] <= dst_a_x;
			dst_s1[0][1] <= dst_a_y;
			dst_s1[1][0] <= dst_b_x;
			dst_s1[1][1] <= dst_b_y;
			dst_s1[2][0] <= dst_c_x;
			dst_s1[2][1] <= dst_c_y;
		end
		if (en_s2) begin
			for (int u = 0; u < 3; u++) begin
				a2_s2[u] <= A2W'(pa_s1[u]) - A2W'(pb_s1[u]);
			end
			d0_s2  <= d0_s1;
			d1_s2  <= d1_s1;
			dst_s2 <= dst_s1;
		end
		if (en_s3) begin
			det_s3 <= DW'(a2_s2[0]) + DW'(a2_s2[1]) + DW'(a2_s2[2]);
			for (int u = 0; u < 3; u++) begin
				for (int j = 0; j < 2; j++) begin
					p0_s3[u][j] <= P01W'(d0_s2[u]) * P01W'(dst_s2[u][j]);
					p1_s3[u][j] <= P01W'(d1_s2[u]) * P01W'(dst_s2[u][j]);
					p2_s3[u][j] <= P2W'(a2_s2[u]) * P2W'(dst_s2[u][j]);
				end
			end
		end
		if (en_s4) begin
			det_s4 <= det_s3;
			for (int j = 0; j < 2; j++) begin
				num_s4[j]     <= NW'(p0_s3[0][j]) + NW'(p0_s3[1][j]) + NW'(p0_s3[2][j]);
				num_s4[2 + j] <= NW'(p1_s3[0][j]) + NW'(p1_s3[1][j]) + NW'(p1_s3[2][j]);
				num_s4[4 + j] <= NW'(p2_s3[0][j]) + NW'(p2_s3[1][j]) + NW'(p2_s3[2][j]);
			end
		end
	end

	// Operand preparation: magnitudes, result sign and the early overflow
	// test. A quotient of 2^QB or more can only saturate, so the divider
	// resolves just the low QB bits and starts with the upper numerator bits.
	logic [DW-1:0]      ud_c;
	logic [NW-1:0]      mag_c [LANES];
	logic [NW+FB-1:0]   nsh_c [LANES];
	div_lane_t          prep_c [LANES];

	always_comb begin
		ud_c = det_s4[DW-1] ? DW'(-det_s4) : DW'(det_s4);
		for (int l = 0; l < LANES; l++) begin
			mag_c[l] = num_s4[l][NW-1] ? NW'(-num_s4[l]) : NW'(num_s4[l]);
			nsh_c[l] = {mag_c[l], {FB{1'b0}}};
			prep_c[l].neg = num_s4[l][NW-1] ^ det_s4[DW-1];
			prep_c[l].presat = (NW+DW)'(mag_c[l]) >= ((NW+DW)'(ud_c) << (QB - FB));
			prep_c[l].rem = DW'(nsh_c[l][NW+FB-1:QB]);
			prep_c[l].nq = nsh_c[l][QB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_sd[0]) begin
			it_sd[0].ud   <= ud_c;
			it_sd[0].sing <= (det_s4 == '0);
			for (int l = 0; l < LANES; l++) ln_sd[0][l] <= prep_c[l];
		end
	end

	// One restoring step per stage.
	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [DW:0] rr_c [LANES];
		logic        ge_c [LANES];
		div_lane_t   nx_c [LANES];
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				rr_c[l] = {ln_sd[k-1][l].rem, ln_sd[k-1][l].nq[QB-1]};
				ge_c[l] = rr_c[l] >= {1'b0, it_sd[k-1].ud};
				nx_c[l].neg = ln_sd[k-1][l].neg;
				nx_c[l].presat = ln_sd[k-1][l].presat;
				nx_c[l].rem = ge_c[l] ? DW'(rr_c[l] - {1'b0, it_sd[k-1].ud})
				                      : DW'(rr_c[l]);
				nx_c[l].nq = {ln_sd[k-1][l].nq[QB-2:0], ge_c[l]};
			end
		end
		always_ff @(posedge clk) begin
			if (en_sd[k]) begin
				it_sd[k] <= it_sd[k-1];
				for (int l = 0; l < LANES; l++) ln_sd[k][l] <= nx_c[l];
			end
		end
	end

	// Round to nearest (ties away from zero), apply the sign and clip.
	logic [DW-1:0]  half_c [LANES];
	logic [QB:0]    q1_c [LANES];
	logic [QB:0]    lim_c [LANES];
	logic           clip_c [LANES];
	logic [OW-1:0]  val_c [LANES];
	logic           any_sat_c;

	always_comb begin
		any_sat_c = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			half_c[l] = it_sd[QB].ud - ln_sd[QB][l].rem;
			q1_c[l] = {1'b0, ln_sd[QB][l].nq}
			        + (QB+1)'(ln_sd[QB][l].rem >= half_c[l]);
			lim_c[l] = ln_sd[QB][l].neg ? (QB+1)'(1) << (OW - 1)
			                            : ((QB+1)'(1) << (OW - 1)) - (QB+1)'(1);
			clip_c[l] = ln_sd[QB][l].presat || (q1_c[l] > lim_c[l]);
			if (clip_c[l])
				val_c[l] = ln_sd[QB][l].neg ? {1'b1, {(OW-1){1'b0}}}
				                            : {1'b0, {(OW-1){1'b1}}};
			else
				val_c[l] = ln_sd[QB][l].neg ? OW'(-q1_c[l]) : OW'(q1_c[l]);
			if (it_sd[QB].sing) val_c[l] = '0;
			any_sat_c = any_sat_c | clip_c[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en_so) begin
			res_so  <= val_c;
			sing_so <= it_sd[QB].sing;
			sat_so  <= any_sat_c && !it_sd[QB].sing;
		end
	end

	assign out_valid = v_so;
	assign coef_xx   = res_so[0];
	assign coef_xy   = res_so[1];
	assign coef_yx   = res_so[2];
	assign coef_yy   = res_so[3];
	assign shift_x   = res_so[4];
	assign shift_y   = res_so[5];
	assign singular  = sing_so;
	assign saturated = sat_so;

	// A singular request never reports clipping and carries zero coefficients.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> !saturated && coef_xx == '0 && shift_y == '0)
		else $error("singular result with nonzero payload");

	// An empty first stage always takes a request.
	a_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled while first stage is empty");

	// A request on a free output path moves into the output register.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_sd[QB] && !(out_valid && out_stall) |=> out_valid)
		else $error("divider result lost before the output register");

endmodule
